### hw/rtl/lkvc_pkg.sv
// lkvc_pkg: shared constants and controller/datapath link types for the
// LRU key/value cache core. No dependencies.
`default_nettype none

package lkvc_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int          CAP_BITS  = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic decide;  // register lookup outcome
    logic commit;  // write back entry state, load result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register holds a transaction not yet taken
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/lkvc_ctrl.sv
// lkvc_ctrl: request sequencer (idle, lookup, update) for the LRU cache.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lkvc_pkg::dp_stat_t stat,
  output lkvc_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       commit;

  assign commit   = (state_r == ST_UPD) && !stat.out_busy;
  // the next request is taken in the same cycle as the write-back
  assign in_ready = (state_r == ST_IDLE) || commit;

  assign cmd.load   = in_valid && in_ready;
  assign cmd.decide = (state_r == ST_LOOK);
  assign cmd.commit = commit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (commit) state_nxt = in_valid ? ST_LOOK : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/lkvc_datapath.sv
// lkvc_datapath: entry lanes (key, value, valid, rank), parallel compare,
// victim and free-slot selection, capacity register and result register.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_datapath #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS,
  localparam int CW        = $clog2(ENTRIES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lkvc_pkg::ctrl_cmd_t           cmd,
  output lkvc_pkg::dp_stat_t                 stat,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data,
  input  wire logic                          in_func,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [VALUE_BITS-1:0]              out_read_value,
  output logic [CW-1:0]                      out_occupancy,
  output logic                               out_evicted,
  output logic [KEY_BITS-1:0]                out_evicted_key
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int MW = (CW > lkvc_pkg::CAP_BITS) ? CW : lkvc_pkg::CAP_BITS;

  // entry lanes
  logic [KEY_BITS-1:0]   ent_key_r [ENTRIES];
  logic [VALUE_BITS-1:0] ent_val_r [ENTRIES];
  logic [ENTRIES-1:0]    ent_vld_r;
  logic [RW-1:0]         ent_rank_r [ENTRIES];
  logic [CW-1:0]         count_r;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_r;

  // captured request
  logic                  req_func_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_val_r;

  // lookup outcome
  logic                  act_r, hit_r, wkey_r, wval_r, alloc_r, ev_r;
  logic [IW-1:0]         tgt_idx_r;
  logic [RW-1:0]         tgt_rank_r;
  logic [VALUE_BITS-1:0] rd_r;
  logic [KEY_BITS-1:0]   evkey_r;

  // result register
  logic                  out_vld_r;
  logic                  o_hit_r, o_ev_r;
  logic [VALUE_BITS-1:0] o_rd_r;
  logic [CW-1:0]         o_occ_r;
  logic [KEY_BITS-1:0]   o_evkey_r;

  // lookup combinational
  logic [ENTRIES-1:0]    match, victim;
  logic                  hit, free_any, full;
  logic [IW-1:0]         hit_idx, vic_idx, free_idx;
  logic [RW-1:0]         hit_rank, vic_rank;
  logic [VALUE_BITS-1:0] hit_val;
  logic [KEY_BITS-1:0]   vic_key;
  logic [CW-1:0]         lru_rank;
  logic [MW-1:0]         cap_ext, cap_eff;
  logic [CW-1:0]         count_nxt;

  assign lru_rank = count_r - CW'(1);
  assign cap_ext  = MW'(cap_r);
  assign cap_eff  = (cap_ext == '0) ? MW'(1) :
                    (cap_ext > MW'(ENTRIES)) ? MW'(ENTRIES) : cap_ext;
  assign full     = MW'(count_r) >= cap_eff;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = ent_vld_r[i] && (ent_key_r[i] == req_key_r);
      victim[i] = ent_vld_r[i] && (CW'(ent_rank_r[i]) == lru_rank);
    end
  end

  // lowest matching lane, lowest free lane; the victim is unique among valid ranks
  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    vic_idx  = '0;
    free_idx = '0;
    hit_val  = '0;
    vic_key  = '0;
    hit_rank = '0;
    vic_rank = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (victim[i]) vic_idx = IW'(i);
      if (!ent_vld_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_idx == IW'(i)) begin
        hit_val  = ent_val_r[i];
        hit_rank = ent_rank_r[i];
      end
      if (vic_idx == IW'(i)) begin
        vic_key  = ent_key_r[i];
        vic_rank = ent_rank_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func_r <= in_func;
      req_key_r  <= in_key;
      req_val_r  <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (cmd.decide) begin
      act_r <= hit || (req_func_r == lkvc_pkg::FUNC_PUT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      hit_r      <= hit;
      rd_r       <= (hit && req_func_r == lkvc_pkg::FUNC_GET) ? hit_val : '0;
      wval_r     <= req_func_r == lkvc_pkg::FUNC_PUT;
      wkey_r     <= !hit;
      alloc_r    <= !hit && !full && free_any;
      ev_r       <= !hit && req_func_r == lkvc_pkg::FUNC_PUT && full;
      evkey_r    <= (!hit && full) ? vic_key : '0;
      if (hit) begin
        tgt_idx_r  <= hit_idx;
        tgt_rank_r <= hit_rank;
      end else if (full) begin
        tgt_idx_r  <= vic_idx;
        tgt_rank_r <= vic_rank;
      end else begin
        tgt_idx_r  <= free_idx;
        tgt_rank_r <= '0;
      end
    end
  end

  assign count_nxt = count_r + CW'(alloc_r);

  // write-back: target lane becomes most recent, more recent lanes age by one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      count_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) ent_rank_r[i] <= '0;
    end else if (cmd.commit && act_r) begin
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_idx_r == IW'(i)) begin
          ent_rank_r[i] <= '0;
          if (alloc_r) ent_vld_r[i] <= 1'b1;
        end else if (ent_vld_r[i] && (alloc_r || ent_rank_r[i] < tgt_rank_r)) begin
          ent_rank_r[i] <= ent_rank_r[i] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && act_r) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_idx_r == IW'(i)) begin
          if (wkey_r) ent_key_r[i] <= req_key_r;
          if (wval_r) ent_val_r[i] <= req_val_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         cap_r <= lkvc_pkg::CAP_RESET;
    else if (cfg_wr_en) cap_r <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)             out_vld_r <= 1'b0;
    else if (cmd.commit)    out_vld_r <= 1'b1;
    else if (out_ready)     out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_hit_r   <= act_r && hit_r;
      o_rd_r    <= act_r ? rd_r : '0;
      o_occ_r   <= act_r ? count_nxt : count_r;
      o_ev_r    <= act_r && ev_r;
      o_evkey_r <= (act_r && ev_r) ? evkey_r : '0;
    end
  end

  assign stat.out_busy   = out_vld_r && !out_ready;
  assign out_valid       = out_vld_r;
  assign out_hit         = o_hit_r;
  assign out_read_value  = o_rd_r;
  assign out_occupancy   = o_occ_r;
  assign out_evicted     = o_ev_r;
  assign out_evicted_key = o_evkey_r;

endmodule

`default_nettype wire

### hw/rtl/lru_key_value_cache_core.sv
// lru_key_value_cache_core: top level of the fully associative LRU cache.
// Instantiates lkvc_ctrl and lkvc_datapath; depends on lkvc_pkg.
//
//   port group  dir  handshake           carries
//   in_*        in   in_valid/in_ready   func, key, value
//   out_*       out  out_valid/out_ready hit, read_value, occupancy, evicted, evicted_key
//   cfg_*       in   cfg_wr_en           capacity (5 bits)
//
// Each transaction passes a lookup state (parallel key compare and
// victim/free-slot pick) and an update state (rank and entry write-back,
// during which the next transaction is taken). out_valid rises when the
// result register is loaded at write-back, after the lookup state.
// A stalled result register holds the write-back and so in_ready.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 16.
`default_nettype none

module lru_key_value_cache_core #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS,
  localparam int CW        = $clog2(ENTRIES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [VALUE_BITS-1:0]              out_read_value,
  output logic [CW-1:0]                      out_occupancy,
  output logic                               out_evicted,
  output logic [KEY_BITS-1:0]                out_evicted_key
);

  lkvc_pkg::ctrl_cmd_t cmd;
  lkvc_pkg::dp_stat_t  stat;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_occupancy   (out_occupancy),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

`default_nettype wire

### tb/lru_key_value_cache_core_tb.sv
// Self-checking testbench for lru_key_value_cache_core: LRU cache predictor,
// directed and random request streams, capacity sweeps and output stalls.
// Depends on lkvc_pkg and the lru_key_value_cache_core RTL.
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb;

  localparam int ENTRIES    = lkvc_pkg::DEF_ENTRIES;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic [4:0]  occupancy;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_func = lkvc_pkg::FUNC_GET;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_hit;
  logic [31:0] out_read_value;
  logic [4:0]  out_occupancy;
  logic        out_evicted;
  logic [31:0] out_evicted_key;

  // cache shadow state
  logic [31:0] shadow_key [ENTRIES];
  logic [31:0] shadow_val [ENTRIES];
  bit          shadow_valid [ENTRIES];
  int unsigned shadow_rank [ENTRIES];
  int unsigned shadow_count;
  logic [4:0]  shadow_capacity;

  cache_reply_t replies_due [$];
  int          mismatch_count = 0;
  int          hold_req_cnt = 0;
  int          hold_ack_cnt = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          rx_step = 0;

  lru_key_value_cache_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_occupancy   (out_occupancy),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int effective_capacity(logic [4:0] cap);
    if (cap < 1) return 1;
    if (cap > ENTRIES) return ENTRIES;
    return int'(cap);
  endfunction

  // move entry to the front; entries that were more recent slide back by one
  function automatic void promote_entry(int idx);
    int unsigned r;
    r = shadow_rank[idx];
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[idx] = 0;
  endfunction

  function automatic cache_reply_t lru_access(logic func, logic [31:0] key,
                                              logic [31:0] value);
    cache_reply_t r;
    int found;
    int victim;
    int slot;
    r = '0;
    found = -1;
    victim = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (func == lkvc_pkg::FUNC_GET) r.read_value = shadow_val[found];
      else shadow_val[found] = value;
      promote_entry(found);
    end else if (func == lkvc_pkg::FUNC_PUT) begin
      if (shadow_count >= effective_capacity(shadow_capacity)) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
            victim = i;
        end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = shadow_key[victim];
          shadow_key[victim] = key;
          shadow_val[victim] = value;
          promote_entry(victim);
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i]) shadow_rank[i]++;
          end
          shadow_valid[slot] = 1'b1;
          shadow_key[slot] = key;
          shadow_val[slot] = value;
          shadow_rank[slot] = 0;
          shadow_count++;
        end
      end
    end
    r.occupancy = shadow_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
  endtask

  // one request transaction; valid stays up until accepted
  task automatic send_request(input logic func, input logic [31:0] key,
                              input logic [31:0] value);
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    replies_due = {replies_due, lru_access(func, key, value)};
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    pause_sender(1);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] cap);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_capacity = cap;
  endtask

  task automatic test_basic_requests();
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);  // miss on empty cache
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h5555_AAAA);  // update in place
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_GET, 32'h1234_5678, 32'h0000_0000);
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd3);
    send_request(lkvc_pkg::FUNC_PUT, 32'hA5A5_0001, 32'h0F0F_0F0F);  // fills last free slot
    send_request(lkvc_pkg::FUNC_PUT, 32'hA5A5_0002, 32'hF0F0_F0F0);  // evicts least recent
    send_request(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    // zero acts as one; occupancy above capacity stays put
    set_capacity(5'd0);
    send_request(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::FUNC_GET, 32'hA5A5_0002, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0001, 32'h8000_0001);
    send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0001, 32'hFFFF_FFFF);
    set_capacity(5'd1);
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0001, 32'hDEAD_0000);
    send_request(lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_BEEF);
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  task automatic run_random_phase(input logic [4:0] cap, input int n_items);
    logic [31:0] pool [$];
    int          pool_n;
    int          burst;
    logic [31:0] key;
    set_capacity(cap);
    pool_n = effective_capacity(cap) + int'($urandom_range(1, 6));
    repeat (pool_n) pool = {pool, (($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom)};
    burst = 0;
    for (int k = 0; k < n_items; k++) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 250)) :
                                              int'($urandom_range(1, 30));
        pause_sender(int'($urandom_range(1, 12)));
      end
      burst--;
      key = ($urandom_range(0, 6) == 0) ? $urandom : pool[$urandom_range(0, pool.size() - 1)];
      send_request(1'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(5'd31, 230);
    run_random_phase(5'd16, 230);
    run_random_phase(5'd1, 200);
    run_random_phase(5'd0, 200);
    run_random_phase(5'd8, 230);
    run_random_phase(5'd3, 230);
    run_random_phase(5'd16, 230);
  endtask

  // output held off while requests keep coming, so the core backs up
  task automatic test_output_backpressure();
    logic [31:0] key;
    set_capacity(5'd4);
    hold_req_cnt++;
    for (int k = 0; k < 80; k++) begin
      key = {28'h0000_000, 4'($urandom_range(0, 6))};
      send_request(1'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  // receiver: long hold-off when asked, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      out_ready    <= 1'b0;
      stall_left   <= HOLD_LEN;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 150);
      end
      rx_mode_left--;
      rx_step++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_step % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cache_reply_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with nothing pending", out_read_value, 32'h0);
      end else begin
        want = replies_due.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", 32'(out_hit), 32'(want.hit));
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(out_occupancy), 32'(want.occupancy));
        if (out_evicted !== want.evicted)
          report_mismatch("evicted", 32'(out_evicted), 32'(want.evicted));
        if (out_evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", out_evicted_key, want.evicted_key);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
      shadow_key[i]   = '0;
      shadow_val[i]   = '0;
    end
    shadow_count    = 0;
    shadow_capacity = lkvc_pkg::CAP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_requests();
    test_capacity_limits();
    test_random_traffic();
    test_output_backpressure();

    drain_replies();
    repeat (10) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch("replies still pending", 32'(replies_due.size()), 32'h0);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
